// ===== design/dmx_frame_deframer_core_assert.svh =====
// assertion macros for the dmx frame deframer
// used by the modules that carry concurrent checks; no other dependencies
`ifndef DMX_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define DMX_FRAME_DEFRAMER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DMX_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dmx deframer check failed");
`define DMX_ASSERT_NEVER(label, clk, rst_n, cond) \
	`DMX_ASSERT(label, clk, rst_n, !(cond))
`else
`define DMX_ASSERT(label, clk, rst_n, prop)
`define DMX_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== design/dmxd_pkg.sv =====
// shared types and constants of the dmx frame deframer
// no dependencies
`timescale 1ns / 1ps

package dmxd_pkg;

	localparam int MAX_PORTS_DEF      = 16;
	localparam int UNIVERSE_SLOTS_DEF = 512;
	localparam int QUEUE_DEPTH        = 2;

	localparam int HALF_BITS = 7;

	localparam logic [7:0] SEND_TYPE_RST  = 8'd128;
	localparam logic [7:0] EVENT_TYPE_RST = 8'd129;

	typedef enum logic [2:0] {
		KIND_WRITE   = 3'd0,
		KIND_BADPORT = 3'd1,
		KIND_UNREG   = 3'd2,
		KIND_TYPE    = 3'd3,
		KIND_CUT     = 3'd4,
		KIND_EMPTY   = 3'd5,
		KIND_LONG    = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		REG_PORT_COUNT      = 2'd0,
		REG_PORT_REGISTERED = 2'd1,
		REG_SEND_TYPE       = 2'd2,
		REG_EVENT_TYPE      = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [4:0]  port_count;
		logic [15:0] port_registered;
		logic [7:0]  send_type;
		logic [7:0]  event_type;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] port;
		logic [6:0] value;
	} res_head_t;

endpackage

// ===== design/dmxd_front.sv =====
// byte parser: frame header tracking, checks and classification of each beat
// depends on dmxd_pkg
`timescale 1ns / 1ps

module dmxd_front import dmxd_pkg::*; #(
	parameter int MAX_PORTS      = MAX_PORTS_DEF,
	parameter int UNIVERSE_SLOTS = UNIVERSE_SLOTS_DEF,
	parameter int LEFT_W         = $clog2(UNIVERSE_SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  cfg_t              cfg,
	input  logic              full,
	output logic              push,
	output res_head_t         push_head,
	output logic [LEFT_W-1:0] push_left
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TYPE,
		PH_PORT,
		PH_LENHI,
		PH_DATA,
		PH_DONE
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  type_q;
	logic [6:0]  port_q;
	logic [13:0] left_q;
	logic        dropping_q;

	logic        accept;
	logic        is_type;
	logic [13:0] len;
	kind_t       check;

	assign in_ready = !full;
	assign accept   = in_valid && !full;
	assign is_type  = rx_byte[7];
	assign len      = {left_q[13:HALF_BITS], rx_byte[HALF_BITS-1:0]};

	// header checks in priority order
	always_comb begin
		if (len == 14'd0) begin
			check = KIND_EMPTY;
		end else if (type_q != cfg.send_type && type_q != cfg.event_type) begin
			check = KIND_TYPE;
		end else if (port_q >= {2'b00, cfg.port_count} || 32'(port_q) >= MAX_PORTS) begin
			check = KIND_BADPORT;
		end else if (port_q >= 7'd16 || !cfg.port_registered[port_q[3:0]]) begin
			check = KIND_UNREG;
		end else if (32'(len) > UNIVERSE_SLOTS) begin
			check = KIND_LONG;
		end else begin
			check = KIND_WRITE;
		end
	end

	always_comb begin
		push            = 1'b0;
		push_head.kind  = KIND_WRITE;
		push_head.port  = port_q[3:0];
		push_head.value = 7'd0;
		push_left       = '0;
		if (accept) begin
			if (is_type) begin
				if (phase_q == PH_TYPE || phase_q == PH_PORT || phase_q == PH_LENHI ||
						(phase_q == PH_DATA && !dropping_q)) begin
					push           = 1'b1;
					push_head.kind = KIND_CUT;
				end
			end else begin
				case (phase_q)
					PH_LENHI: begin
						if (check != KIND_WRITE) begin
							push           = 1'b1;
							push_head.kind = check;
						end
					end
					PH_DATA: begin
						if (left_q != 14'd0 && !dropping_q) begin
							push            = 1'b1;
							push_head.value = rx_byte[6:0];
							push_left       = left_q[LEFT_W-1:0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			type_q     <= 8'd0;
			port_q     <= 7'd0;
			left_q     <= 14'd0;
			dropping_q <= 1'b0;
		end else if (accept) begin
			if (is_type) begin
				type_q     <= rx_byte;
				port_q     <= 7'd0;
				left_q     <= 14'd0;
				dropping_q <= 1'b0;
				phase_q    <= PH_TYPE;
			end else begin
				case (phase_q)
					PH_TYPE: begin
						port_q  <= rx_byte[6:0];
						phase_q <= PH_PORT;
					end
					PH_PORT: begin
						left_q  <= {rx_byte[6:0], 7'd0};
						phase_q <= PH_LENHI;
					end
					PH_LENHI: begin
						left_q <= len;
						if (check == KIND_EMPTY) begin
							phase_q <= PH_DONE;
						end else begin
							phase_q <= PH_DATA;
							if (check != KIND_WRITE) begin
								dropping_q <= 1'b1;
							end
						end
					end
					PH_DATA: begin
						if (left_q <= 14'd1) begin
							phase_q    <= PH_DONE;
							dropping_q <= 1'b0;
						end
						if (left_q != 14'd0) begin
							left_q <= left_q - 14'd1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== design/dmxd_queue.sv =====
// short result queue between parser and output stage
// depends on dmxd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "dmx_frame_deframer_core_assert.svh"

module dmxd_queue import dmxd_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// the parser must hold off when full, the output stage when empty
	`DMX_ASSERT_NEVER(a_push_full, clk, arst_n, push && full)
	`DMX_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && empty)
	`DMX_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(DEPTH))

endmodule

// ===== design/dmxd_back.sv =====
// output stage: slot and last computation, result register toward the receiver
// depends on dmxd_pkg
`timescale 1ns / 1ps

module dmxd_back import dmxd_pkg::*; #(
	parameter int UNIVERSE_SLOTS = UNIVERSE_SLOTS_DEF,
	parameter int LEFT_W         = $clog2(UNIVERSE_SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  res_head_t         head,
	input  logic [LEFT_W-1:0] left,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        kind,
	output logic [3:0]        port,
	output logic [8:0]        slot,
	output logic [6:0]        value,
	output logic              last
);

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [3:0]  port_q;
	logic [8:0]  slot_q;
	logic [6:0]  value_q;
	logic        last_q;
	logic        is_write;
	logic [9:0]  slot_full;

	assign pop       = !empty && (!out_valid_q || out_ready);
	assign is_write  = head.kind == KIND_WRITE;
	// slot counts up as the remaining count runs down
	assign slot_full = 10'(UNIVERSE_SLOTS) - 10'(left);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= head.kind;
			port_q  <= head.port;
			value_q <= is_write ? head.value : 7'd0;
			slot_q  <= is_write ? slot_full[8:0] : 9'd0;
			last_q  <= is_write && (left == LEFT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign port      = port_q;
	assign slot      = slot_q;
	assign value     = value_q;
	assign last      = last_q;

endmodule

// ===== design/dmx_frame_deframer_core.sv =====
// top level of the dmx frame deframer: config registers, parser, queue, output stage
// depends on dmxd_pkg, dmxd_front, dmxd_queue and dmxd_back
`timescale 1ns / 1ps

// usage:
// - input channel in_valid/in_ready/rx_byte: one link byte per beat; a byte with
//   its top bit set opens a frame (type), then port, length high, length low, data
// - output channel out_valid/out_ready: one result beat per data byte of an
//   accepted frame (kind write, slot, value, last on the final byte) or one status
//   beat per header error or cut-off frame; other bytes give nothing
// - config channel cfg_valid/cfg_ready/cfg_index/cfg_data: always ready, one
//   register per beat; write only while the block is idle
// - throughput: one byte per cycle, sustained, as long as the receiver keeps up;
//   the parser updates its small header state with each accepted byte
// - path: the parser writes a result into the queue at the edge that takes its
//   byte, and the output register loads it from the queue once that register is
//   free
// - stall: while the receiver holds out_ready low, results pile up in the queue;
//   in_ready drops only once the queue is full, so no beat is lost
// - reset: parser goes idle, queue and output register empty, registers take
//   port_count 0, no ports registered, send type 128, event type 129
module dmx_frame_deframer_core import dmxd_pkg::*; #(
	parameter int MAX_PORTS      = MAX_PORTS_DEF,
	parameter int UNIVERSE_SLOTS = UNIVERSE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [3:0]  port,
	output logic [8:0]  slot,
	output logic [6:0]  value,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int LEFT_W  = $clog2(UNIVERSE_SLOTS + 1);
	localparam int HEAD_W  = $bits(res_head_t);
	localparam int ENTRY_W = HEAD_W + LEFT_W;

	cfg_t cfg_q;

	// parser to queue
	logic              push;
	res_head_t         push_head;
	logic [LEFT_W-1:0] push_left;
	logic              full;

	// queue to output stage
	logic               pop;
	logic               empty;
	logic [ENTRY_W-1:0] pop_data;
	res_head_t          pop_head;
	logic [LEFT_W-1:0]  pop_left;

	// config registers, written one beat at a time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.port_count      <= 5'd0;
			cfg_q.port_registered <= 16'd0;
			cfg_q.send_type       <= SEND_TYPE_RST;
			cfg_q.event_type      <= EVENT_TYPE_RST;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_PORT_COUNT:      cfg_q.port_count      <= cfg_data[4:0];
				REG_PORT_REGISTERED: cfg_q.port_registered <= cfg_data;
				REG_SEND_TYPE:       cfg_q.send_type       <= cfg_data[7:0];
				REG_EVENT_TYPE:      cfg_q.event_type      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// front: header tracking and classification of each byte
	dmxd_front #(
		.MAX_PORTS      (MAX_PORTS),
		.UNIVERSE_SLOTS (UNIVERSE_SLOTS),
		.LEFT_W         (LEFT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.full      (full),
		.push      (push),
		.push_head (push_head),
		.push_left (push_left)
	);

	// queue decouples the parser from receiver stalls
	dmxd_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_head, push_left}),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	assign pop_head = res_head_t'(pop_data[ENTRY_W-1:LEFT_W]);
	assign pop_left = pop_data[LEFT_W-1:0];

	// back: slot numbering and the output register
	dmxd_back #(
		.UNIVERSE_SLOTS (UNIVERSE_SLOTS),
		.LEFT_W         (LEFT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (pop_head),
		.left      (pop_left),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.port      (port),
		.slot      (slot),
		.value     (value),
		.last      (last)
	);

endmodule
